// File: hw/rtl/ccsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circumcircle steering angle package
// Widths, constants, cell payload types and the per-cell step functions
// shared by the divider, square root and CORDIC chains.
// ----------------------------------------------------------------------------
package ccsa_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 20;
    localparam int GUARD_BITS    = 24;
    localparam int ANGLE_W       = FRAC_BITS + 2;
    localparam int COORD_W       = 32;
    localparam int WB_W          = 31;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int SQ_W          = 2 * DIFF_W;
    localparam int DET_W         = SQ_W + 1;
    localparam int PP_W          = 2 * DIFF_W + 1;
    localparam int NUM_W         = 101;
    localparam int DEN_W         = DET_W;
    localparam int DIV_STAGES    = 40;
    localparam int MAG_W         = DIV_STAGES + 1;
    localparam int SQRT_STAGES   = COORD_W;
    localparam int ROOT_W        = COORD_W;
    localparam int REM_W         = ROOT_W + 2;
    localparam int CXY_W         = 60;
    localparam int Z_W           = 36;
    localparam int STAGE_W       = $clog2(CORDIC_STAGES);
    localparam int ATAN_N        = 12;
    localparam int LATENCY       = 10 + DIV_STAGES + 2 + SQRT_STAGES + 1 + CORDIC_STAGES + 2;

    localparam logic [WB_W-1:0]        WB_RESET    = 31'd131072;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q32 = 36'sd6746518852;
    localparam int ANGLE_MAX = int'((64'd6746518852 + (64'd1 << (31 - FRAC_BITS)))
                                    >> (32 - FRAC_BITS));

    localparam logic [Z_W-1:0] ATAN_Q32 [ATAN_N] = '{
        36'd3373259426, 36'd1991351317, 36'd1052175346, 36'd534100635,
        36'd268086748,  36'd134174063,  36'd67103403,   36'd33553749,
        36'd16777131,   36'd8388597,    36'd4194303,    36'd2097152
    };

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        logic [DEN_W-1:0]      d;
        logic [DEN_W-1:0]      rem;
        logic [DIV_STAGES-1:0] num;
        logic [DIV_STAGES-1:0] quo;
        logic                  ovf;
        logic                  neg;
    } div_lane_t;

    typedef struct packed {
        div_lane_t                  lx;
        div_lane_t                  ly;
        logic signed [COORD_W-1:0]  gx;
        logic signed [COORD_W-1:0]  gy;
        logic                       zero;
    } div_t;

    typedef struct packed {
        logic [2*SQRT_STAGES-1:0]   v;
        logic [REM_W-1:0]           rem;
        logic [ROOT_W-1:0]          root;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic                       sat;
        logic                       big;
        logic                       right;
        logic                       zero;
    } sqrt_t;

    typedef struct packed {
        logic signed [CXY_W-1:0]    x;
        logic signed [CXY_W-1:0]    y;
        logic signed [Z_W-1:0]      z;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic [COORD_W-1:0]         rad;
        logic                       sat;
        logic                       right;
        logic                       zero;
        logic                       rad_zero;
    } cordic_t;

    function automatic div_lane_t div_step(div_lane_t a);
        div_lane_t        r;
        logic [DEN_W:0]   rem2;
        logic [DEN_W:0]   diff;
        r    = a;
        rem2 = {a.rem, a.num[DIV_STAGES-1]};
        diff = rem2 - {1'b0, a.d};
        r.num = {a.num[DIV_STAGES-2:0], 1'b0};
        if (rem2 >= {1'b0, a.d})
        begin
            r.rem = diff[DEN_W-1:0];
            r.quo = {a.quo[DIV_STAGES-2:0], 1'b1};
        end
        else
        begin
            r.rem = rem2[DEN_W-1:0];
            r.quo = {a.quo[DIV_STAGES-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic sqrt_t sqrt_step(sqrt_t a);
        sqrt_t            r;
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;
        r      = a;
        rem_sh = {a.rem, a.v[2*SQRT_STAGES-1 -: 2]};
        trial  = {{(REM_W-ROOT_W){1'b0}}, a.root, 2'b01};
        diff   = rem_sh - trial;
        r.v    = {a.v[2*SQRT_STAGES-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            r.rem  = diff[REM_W-1:0];
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = rem_sh[REM_W-1:0];
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic signed [Z_W-1:0] atan_step(logic [STAGE_W-1:0] i);
        logic [Z_W-1:0] r;
        if (int'(i) < ATAN_N)
            r = ATAN_Q32[i[3:0]];
        else
            r = {{(Z_W-1){1'b0}}, 1'b1} << (32 - int'(i));
        return $signed(r);
    endfunction

endpackage

// File: hw/rtl/circumcircle_steering_angle_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circumcircle steering angle unit
// Finds the circle through a goal point and two robot corners, its radius
// and the front steering angle atan(wheel_base / radius).
//
// Usage: pulse start with the six Q16.16 coordinates; busy stays low, so a
// new transfer may be started in every cycle. Each item produces one result,
// shown for exactly one cycle with done high, after it passes through
// 10 front-end stages, 40 divider cells, 2 stages, 32 square root cells,
// 1 stage, 20 CORDIC cells and 2 output stages. Throughput is one item per
// cycle; the one-bit-per-cell divider and root chains are most of its depth.
// The receiver takes every result and cannot stall the pipeline.
// The wheel_base register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high. Write it only when no items are in flight.
// Reset clears all valid bits and sets wheel_base to 2.0 m; status is
// 0 ok, 1 collinear points, 2 saturated output.
// ----------------------------------------------------------------------------
module circumcircle_steering_angle_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [ccsa_pkg::COORD_W-1:0]  goal_x,
    input  logic signed [ccsa_pkg::COORD_W-1:0]  goal_y,
    input  logic signed [ccsa_pkg::COORD_W-1:0]  front_x,
    input  logic signed [ccsa_pkg::COORD_W-1:0]  front_y,
    input  logic signed [ccsa_pkg::COORD_W-1:0]  rear_x,
    input  logic signed [ccsa_pkg::COORD_W-1:0]  rear_y,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ccsa_pkg::WB_W-1:0]            cfg_data,
    output logic                                 done,
    output logic signed [ccsa_pkg::COORD_W-1:0]  center_x,
    output logic signed [ccsa_pkg::COORD_W-1:0]  center_y,
    output logic [ccsa_pkg::COORD_W-1:0]         radius,
    output logic signed [ccsa_pkg::ANGLE_W-1:0]  steer_angle,
    output logic [1:0]                           status
);
    import ccsa_pkg::*;

    localparam int HI_W = NUM_W - DIV_STAGES;
    localparam int CV_W = MAG_W + 2;
    localparam logic signed [CV_W-1:0] C_MAX =
        {{(CV_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [CV_W-1:0] C_MIN =
        {{(CV_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
    localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {(MAG_W-1){1'b0}}};

    function automatic logic signed [NUM_W-1:0] join_pp(
        logic signed [PP_W-1:0] hi, logic signed [PP_W-1:0] lo);
        return ({{(NUM_W-PP_W){hi[PP_W-1]}}, hi} << DIFF_W)
               + {{(NUM_W-PP_W){lo[PP_W-1]}}, lo};
    endfunction

    logic [WB_W-1:0] wheel_base_reg;
    logic [9:0]      front_vld_reg;

    logic signed [COORD_W-1:0] s0_gx_reg, s0_gy_reg, s0_fx_reg, s0_fy_reg, s0_rx_reg, s0_ry_reg;
    logic signed [COORD_W-1:0] s1_gx_reg, s1_gy_reg, s2_gx_reg, s2_gy_reg, s3_gx_reg, s3_gy_reg;
    logic signed [COORD_W-1:0] s4_gx_reg, s4_gy_reg, s5_gx_reg, s5_gy_reg, s6_gx_reg, s6_gy_reg;
    logic signed [COORD_W-1:0] s7_gx_reg, s7_gy_reg, s8_gx_reg, s8_gy_reg;
    logic signed [DIFF_W-1:0]  s1_ux_reg, s1_uy_reg, s1_vx_reg, s1_vy_reg;
    logic signed [DIFF_W-1:0]  s2_ux_reg, s2_uy_reg, s2_vx_reg, s2_vy_reg;
    logic signed [DIFF_W-1:0]  s3_ux_reg, s3_uy_reg, s3_vx_reg, s3_vy_reg;
    logic signed [SQ_W-1:0]    s2_uxux_reg, s2_uyuy_reg, s2_vxvx_reg, s2_vyvy_reg;
    logic signed [SQ_W-1:0]    s2_uxvy_reg, s2_uyvx_reg;
    logic [SQ_W-1:0]           s3_usq_reg, s3_vsq_reg;
    logic signed [DET_W-1:0]   s3_det_reg, s4_det_reg, s5_det_reg, s6_det_reg;
    logic signed [PP_W-1:0]    s4_alo_reg, s4_ahi_reg, s4_blo_reg, s4_bhi_reg;
    logic signed [PP_W-1:0]    s4_clo_reg, s4_chi_reg, s4_dlo_reg, s4_dhi_reg;
    logic signed [NUM_W-1:0]   s5_pa_reg, s5_pb_reg, s5_pc_reg, s5_pd_reg;
    logic signed [NUM_W-1:0]   s6_nx_reg, s6_ny_reg;
    logic [NUM_W-1:0]          s7_anx_reg, s7_any_reg;
    logic [DEN_W-1:0]          s7_adet_reg;
    logic                      s7_negx_reg, s7_negy_reg, s7_zero_reg;
    logic [NUM_W-1:0]          s8_nx_reg, s8_ny_reg;
    logic [DEN_W-1:0]          s8_d_reg;
    logic                      s8_negx_reg, s8_negy_reg, s8_zero_reg;
    div_t                      s9_reg;
    div_t                      s9_next;
    logic [HI_W-1:0]           hi_x, hi_y;

    div_t                      div_d [DIV_STAGES+1];
    logic [DIV_STAGES:0]       div_v;

    logic [MAG_W-1:0]          mx, my;
    logic [CV_W-1:0]           mxe, mye;
    logic signed [CV_W-1:0]    cxv, cyv;
    logic                      p1_vld_reg, p1_sat_reg, p1_big_reg, p1_right_reg, p1_zero_reg;
    logic signed [COORD_W-1:0] p1_cx_reg, p1_cy_reg;
    logic [2*COORD_W-1:0]      p1_sqx_reg, p1_sqy_reg;
    logic                      p1_sat_next;
    logic signed [COORD_W-1:0] p1_cx_next, p1_cy_next;
    logic                      p2_vld_reg;
    sqrt_t                     p2_reg;
    sqrt_t                     p2_next;
    logic [2*COORD_W:0]        ssum;

    sqrt_t                     sq_d [SQRT_STAGES+1];
    logic [SQRT_STAGES:0]      sq_v;

    sqrt_t                     sq_end;
    logic [ROOT_W:0]           root_rnd;
    logic                      root_ovr;
    logic                      r1_vld_reg;
    cordic_t                   r1_reg;
    cordic_t                   r1_next;

    cordic_t                   cor_d [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0]    cor_v;

    cordic_t                   cq;
    logic signed [Z_W-1:0]     f1_z_next;
    logic signed [Z_W-1:0]     f1_z_reg;
    logic                      f1_vld_reg, f1_sat_reg, f1_right_reg, f1_zero_reg;
    logic signed [COORD_W-1:0] f1_cx_reg, f1_cy_reg;
    logic [COORD_W-1:0]        f1_rad_reg;

    logic [Z_W-1:0]            z_rnd;
    logic [ANGLE_W-1:0]        ang_mag;
    logic                      done_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic [COORD_W-1:0]        rad_reg;
    logic signed [ANGLE_W-1:0] ang_reg;
    status_t                   status_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wheel_base_reg <= WB_RESET;
        else if (cfg_valid && cfg_ready)
            wheel_base_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            r1_vld_reg    <= 1'b0;
            f1_vld_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            front_vld_reg <= {front_vld_reg[8:0], start && !busy};
            p1_vld_reg    <= div_v[DIV_STAGES];
            p2_vld_reg    <= p1_vld_reg;
            r1_vld_reg    <= sq_v[SQRT_STAGES];
            f1_vld_reg    <= cor_v[CORDIC_STAGES];
            done_reg      <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_gx_reg <= goal_x;
        s0_gy_reg <= goal_y;
        s0_fx_reg <= front_x;
        s0_fy_reg <= front_y;
        s0_rx_reg <= rear_x;
        s0_ry_reg <= rear_y;

        s1_gx_reg <= s0_gx_reg;
        s1_gy_reg <= s0_gy_reg;
        s1_ux_reg <= {s0_fx_reg[COORD_W-1], s0_fx_reg} - {s0_gx_reg[COORD_W-1], s0_gx_reg};
        s1_uy_reg <= {s0_fy_reg[COORD_W-1], s0_fy_reg} - {s0_gy_reg[COORD_W-1], s0_gy_reg};
        s1_vx_reg <= {s0_rx_reg[COORD_W-1], s0_rx_reg} - {s0_gx_reg[COORD_W-1], s0_gx_reg};
        s1_vy_reg <= {s0_ry_reg[COORD_W-1], s0_ry_reg} - {s0_gy_reg[COORD_W-1], s0_gy_reg};

        s2_gx_reg   <= s1_gx_reg;
        s2_gy_reg   <= s1_gy_reg;
        s2_ux_reg   <= s1_ux_reg;
        s2_uy_reg   <= s1_uy_reg;
        s2_vx_reg   <= s1_vx_reg;
        s2_vy_reg   <= s1_vy_reg;
        s2_uxux_reg <= s1_ux_reg * s1_ux_reg;
        s2_uyuy_reg <= s1_uy_reg * s1_uy_reg;
        s2_vxvx_reg <= s1_vx_reg * s1_vx_reg;
        s2_vyvy_reg <= s1_vy_reg * s1_vy_reg;
        s2_uxvy_reg <= s1_ux_reg * s1_vy_reg;
        s2_uyvx_reg <= s1_uy_reg * s1_vx_reg;

        s3_gx_reg  <= s2_gx_reg;
        s3_gy_reg  <= s2_gy_reg;
        s3_ux_reg  <= s2_ux_reg;
        s3_uy_reg  <= s2_uy_reg;
        s3_vx_reg  <= s2_vx_reg;
        s3_vy_reg  <= s2_vy_reg;
        s3_usq_reg <= s2_uxux_reg + s2_uyuy_reg;
        s3_vsq_reg <= s2_vxvx_reg + s2_vyvy_reg;
        s3_det_reg <= {s2_uxvy_reg[SQ_W-1], s2_uxvy_reg} - {s2_uyvx_reg[SQ_W-1], s2_uyvx_reg};

        s4_gx_reg  <= s3_gx_reg;
        s4_gy_reg  <= s3_gy_reg;
        s4_det_reg <= s3_det_reg;
        s4_alo_reg <= s3_vy_reg * $signed({1'b0, s3_usq_reg[DIFF_W-1:0]});
        s4_ahi_reg <= s3_vy_reg * $signed({1'b0, s3_usq_reg[SQ_W-1:DIFF_W]});
        s4_blo_reg <= s3_uy_reg * $signed({1'b0, s3_vsq_reg[DIFF_W-1:0]});
        s4_bhi_reg <= s3_uy_reg * $signed({1'b0, s3_vsq_reg[SQ_W-1:DIFF_W]});
        s4_clo_reg <= s3_ux_reg * $signed({1'b0, s3_vsq_reg[DIFF_W-1:0]});
        s4_chi_reg <= s3_ux_reg * $signed({1'b0, s3_vsq_reg[SQ_W-1:DIFF_W]});
        s4_dlo_reg <= s3_vx_reg * $signed({1'b0, s3_usq_reg[DIFF_W-1:0]});
        s4_dhi_reg <= s3_vx_reg * $signed({1'b0, s3_usq_reg[SQ_W-1:DIFF_W]});

        s5_gx_reg  <= s4_gx_reg;
        s5_gy_reg  <= s4_gy_reg;
        s5_det_reg <= s4_det_reg;
        s5_pa_reg  <= join_pp(s4_ahi_reg, s4_alo_reg);
        s5_pb_reg  <= join_pp(s4_bhi_reg, s4_blo_reg);
        s5_pc_reg  <= join_pp(s4_chi_reg, s4_clo_reg);
        s5_pd_reg  <= join_pp(s4_dhi_reg, s4_dlo_reg);

        s6_gx_reg  <= s5_gx_reg;
        s6_gy_reg  <= s5_gy_reg;
        s6_det_reg <= s5_det_reg;
        s6_nx_reg  <= s5_pa_reg - s5_pb_reg;
        s6_ny_reg  <= s5_pc_reg - s5_pd_reg;

        s7_gx_reg   <= s6_gx_reg;
        s7_gy_reg   <= s6_gy_reg;
        s7_anx_reg  <= s6_nx_reg[NUM_W-1] ? -s6_nx_reg : s6_nx_reg;
        s7_any_reg  <= s6_ny_reg[NUM_W-1] ? -s6_ny_reg : s6_ny_reg;
        s7_adet_reg <= s6_det_reg[DET_W-1] ? -s6_det_reg : s6_det_reg;
        s7_negx_reg <= s6_nx_reg[NUM_W-1] ^ s6_det_reg[DET_W-1];
        s7_negy_reg <= s6_ny_reg[NUM_W-1] ^ s6_det_reg[DET_W-1];
        s7_zero_reg <= (s6_det_reg == '0);

        s8_gx_reg   <= s7_gx_reg;
        s8_gy_reg   <= s7_gy_reg;
        s8_nx_reg   <= s7_anx_reg + {{(NUM_W-DEN_W){1'b0}}, s7_adet_reg};
        s8_ny_reg   <= s7_any_reg + {{(NUM_W-DEN_W){1'b0}}, s7_adet_reg};
        s8_d_reg    <= {s7_adet_reg[DEN_W-2:0], 1'b0};
        s8_negx_reg <= s7_negx_reg;
        s8_negy_reg <= s7_negy_reg;
        s8_zero_reg <= s7_zero_reg;

        s9_reg <= s9_next;
    end

    always_comb
    begin
        hi_x            = s8_nx_reg[NUM_W-1:DIV_STAGES];
        hi_y            = s8_ny_reg[NUM_W-1:DIV_STAGES];
        s9_next.gx      = s8_gx_reg;
        s9_next.gy      = s8_gy_reg;
        s9_next.zero    = s8_zero_reg;
        s9_next.lx.d    = s8_d_reg;
        s9_next.ly.d    = s8_d_reg;
        s9_next.lx.num  = s8_nx_reg[DIV_STAGES-1:0];
        s9_next.ly.num  = s8_ny_reg[DIV_STAGES-1:0];
        s9_next.lx.quo  = '0;
        s9_next.ly.quo  = '0;
        s9_next.lx.neg  = s8_negx_reg;
        s9_next.ly.neg  = s8_negy_reg;
        s9_next.lx.ovf  = {{(DEN_W-HI_W){1'b0}}, hi_x} >= s8_d_reg;
        s9_next.ly.ovf  = {{(DEN_W-HI_W){1'b0}}, hi_y} >= s8_d_reg;
        s9_next.lx.rem  = s9_next.lx.ovf ? '0 : {{(DEN_W-HI_W){1'b0}}, hi_x};
        s9_next.ly.rem  = s9_next.ly.ovf ? '0 : {{(DEN_W-HI_W){1'b0}}, hi_y};
    end

    assign div_d[0] = s9_reg;
    assign div_v[0] = front_vld_reg[9];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        ccsa_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_v[i]),
            .in_data   (div_d[i]),
            .out_valid (div_v[i+1]),
            .out_data  (div_d[i+1])
        );
    end

    always_comb
    begin
        mx  = div_d[DIV_STAGES].lx.ovf ? MAG_CAP : {1'b0, div_d[DIV_STAGES].lx.quo};
        my  = div_d[DIV_STAGES].ly.ovf ? MAG_CAP : {1'b0, div_d[DIV_STAGES].ly.quo};
        mxe = {{(CV_W-MAG_W){1'b0}}, mx};
        mye = {{(CV_W-MAG_W){1'b0}}, my};
        cxv = {{(CV_W-COORD_W){div_d[DIV_STAGES].gx[COORD_W-1]}}, div_d[DIV_STAGES].gx}
              + (div_d[DIV_STAGES].lx.neg ? -mxe : mxe);
        cyv = {{(CV_W-COORD_W){div_d[DIV_STAGES].gy[COORD_W-1]}}, div_d[DIV_STAGES].gy}
              + (div_d[DIV_STAGES].ly.neg ? -mye : mye);
        p1_sat_next = 1'b0;
        if (cxv > C_MAX)
        begin
            p1_cx_next  = C_MAX[COORD_W-1:0];
            p1_sat_next = 1'b1;
        end
        else if (cxv < C_MIN)
        begin
            p1_cx_next  = C_MIN[COORD_W-1:0];
            p1_sat_next = 1'b1;
        end
        else
            p1_cx_next = cxv[COORD_W-1:0];
        if (cyv > C_MAX)
        begin
            p1_cy_next  = C_MAX[COORD_W-1:0];
            p1_sat_next = 1'b1;
        end
        else if (cyv < C_MIN)
        begin
            p1_cy_next  = C_MIN[COORD_W-1:0];
            p1_sat_next = 1'b1;
        end
        else
            p1_cy_next = cyv[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        p1_cx_reg    <= p1_cx_next;
        p1_cy_reg    <= p1_cy_next;
        p1_sat_reg   <= p1_sat_next;
        p1_right_reg <= cyv[CV_W-1];
        p1_zero_reg  <= div_d[DIV_STAGES].zero;
        p1_big_reg   <= (|mx[MAG_W-1:COORD_W]) || (|my[MAG_W-1:COORD_W]);
        p1_sqx_reg   <= mx[COORD_W-1:0] * mx[COORD_W-1:0];
        p1_sqy_reg   <= my[COORD_W-1:0] * my[COORD_W-1:0];
        p2_reg       <= p2_next;
    end

    always_comb
    begin
        ssum          = {1'b0, p1_sqx_reg} + {1'b0, p1_sqy_reg};
        p2_next.v     = ssum[2*COORD_W-1:0];
        p2_next.rem   = '0;
        p2_next.root  = '0;
        p2_next.cx    = p1_cx_reg;
        p2_next.cy    = p1_cy_reg;
        p2_next.sat   = p1_sat_reg;
        p2_next.big   = p1_big_reg || ssum[2*COORD_W];
        p2_next.right = p1_right_reg;
        p2_next.zero  = p1_zero_reg;
    end

    assign sq_d[0] = p2_reg;
    assign sq_v[0] = p2_vld_reg;

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_sqrt
        ccsa_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[i]),
            .in_data   (sq_d[i]),
            .out_valid (sq_v[i+1]),
            .out_data  (sq_d[i+1])
        );
    end

    always_comb
    begin
        sq_end   = sq_d[SQRT_STAGES];
        root_rnd = {1'b0, sq_end.root}
                   + {{ROOT_W{1'b0}}, (sq_end.rem > {{(REM_W-ROOT_W){1'b0}}, sq_end.root})};
        root_ovr = root_rnd[ROOT_W];
        r1_next.rad      = (sq_end.big || root_ovr) ? '1 : root_rnd[ROOT_W-1:0];
        r1_next.sat      = sq_end.sat || sq_end.big || root_ovr;
        r1_next.rad_zero = !sq_end.big && (root_rnd == '0);
        r1_next.cx       = sq_end.cx;
        r1_next.cy       = sq_end.cy;
        r1_next.right    = sq_end.right;
        r1_next.zero     = sq_end.zero;
        r1_next.x        = {{(CXY_W-COORD_W){1'b0}}, r1_next.rad} << GUARD_BITS;
        r1_next.y        = {{(CXY_W-WB_W){1'b0}}, wheel_base_reg} << GUARD_BITS;
        r1_next.z        = '0;
    end

    always_ff @(posedge clk)
    begin
        r1_reg <= r1_next;
    end

    assign cor_d[0] = r1_reg;
    assign cor_v[0] = r1_vld_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        ccsa_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (STAGE_W'(i)),
            .in_valid  (cor_v[i]),
            .in_data   (cor_d[i]),
            .out_valid (cor_v[i+1]),
            .out_data  (cor_d[i+1])
        );
    end

    always_comb
    begin
        cq = cor_d[CORDIC_STAGES];
        if (cq.rad_zero || (cq.z > HALF_PI_Q32))
            f1_z_next = HALF_PI_Q32;
        else if (cq.z[Z_W-1])
            f1_z_next = '0;
        else
            f1_z_next = cq.z;
    end

    always_ff @(posedge clk)
    begin
        f1_z_reg     <= f1_z_next;
        f1_cx_reg    <= cq.cx;
        f1_cy_reg    <= cq.cy;
        f1_rad_reg   <= cq.rad;
        f1_sat_reg   <= cq.sat;
        f1_right_reg <= cq.right;
        f1_zero_reg  <= cq.zero;
    end

    always_comb
    begin
        z_rnd   = (f1_z_reg + ({{(Z_W-1){1'b0}}, 1'b1} << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
        ang_mag = z_rnd[ANGLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (f1_zero_reg)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            rad_reg    <= '0;
            ang_reg    <= '0;
            status_reg <= ST_COLLINEAR;
        end
        else
        begin
            cx_reg     <= f1_cx_reg;
            cy_reg     <= f1_cy_reg;
            rad_reg    <= f1_rad_reg;
            ang_reg    <= f1_right_reg ? -ang_mag : ang_mag;
            status_reg <= f1_sat_reg ? ST_SATURATED : ST_OK;
        end
    end

    assign done        = done_reg;
    assign center_x    = cx_reg;
    assign center_y    = cy_reg;
    assign radius      = rad_reg;
    assign steer_angle = ang_reg;
    assign status      = status_reg;

endmodule

// File: hw/rtl/ccsa_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit for both center offsets per cycle.
// ----------------------------------------------------------------------------
module ccsa_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  ccsa_pkg::div_t in_data,
    output logic          out_valid,
    output ccsa_pkg::div_t out_data
);
    import ccsa_pkg::*;

    logic  valid_reg;
    div_t  data_reg;
    div_t  data_next;

    always_comb
    begin
        data_next    = in_data;
        data_next.lx = div_step(in_data.lx);
        data_next.ly = div_step(in_data.ly);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/ccsa_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root cell
// One root bit per cycle from two radicand bits.
// ----------------------------------------------------------------------------
module ccsa_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  ccsa_pkg::sqrt_t in_data,
    output logic           out_valid,
    output ccsa_pkg::sqrt_t out_data
);
    import ccsa_pkg::*;

    logic   valid_reg;
    sqrt_t  data_reg;
    sqrt_t  data_next;

    always_comb
    begin
        data_next = sqrt_step(in_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/ccsa_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring rotation; the stage input selects shift and arctangent step.
// ----------------------------------------------------------------------------
module ccsa_cordic_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ccsa_pkg::STAGE_W-1:0]  stage,
    input  logic                          in_valid,
    input  ccsa_pkg::cordic_t             in_data,
    output logic                          out_valid,
    output ccsa_pkg::cordic_t             out_data
);
    import ccsa_pkg::*;

    logic                    valid_reg;
    cordic_t                 data_reg;
    cordic_t                 data_next;
    logic signed [CXY_W-1:0] xs;
    logic signed [CXY_W-1:0] ys;
    logic signed [Z_W-1:0]   step;

    always_comb
    begin
        xs        = $signed(in_data.x) >>> stage;
        ys        = $signed(in_data.y) >>> stage;
        step      = atan_step(stage);
        data_next = in_data;
        if (!in_data.y[CXY_W-1] && (in_data.y != '0))
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + step;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/ccsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circumcircle steering angle checker
// Port-level checks on result timing and result consistency.
// ----------------------------------------------------------------------------
module ccsa_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 done,
    input logic signed [ccsa_pkg::COORD_W-1:0]  center_x,
    input logic signed [ccsa_pkg::COORD_W-1:0]  center_y,
    input logic [ccsa_pkg::COORD_W-1:0]         radius,
    input logic signed [ccsa_pkg::ANGLE_W-1:0]  steer_angle,
    input logic [1:0]                           status
);
    import ccsa_pkg::*;

    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY) && !$past(busy, LATENCY))
        else $error("result without a start transfer at the pipeline latency");

    a_collinear : assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_COLLINEAR) |->
            (center_x == '0) && (center_y == '0) && (radius == '0) && (steer_angle == '0))
        else $error("collinear result carries nonzero outputs");

    a_right_curve : assert property (@(posedge clk) disable iff (!rst_n)
        done && steer_angle[ANGLE_W-1] |-> center_y[COORD_W-1] && (status != ST_COLLINEAR))
        else $error("negative steering angle with center on the left");

    a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed(steer_angle) <= ANGLE_MAX) && ($signed(steer_angle) >= -ANGLE_MAX))
        else $error("steering angle beyond a quarter turn");

endmodule

bind circumcircle_steering_angle_unit ccsa_checker u_ccsa_checker (.*);
